// ===== src/rrs_pkg.sv =====
// Relay retransmission scheduler: shared types, codes and constants.
// Used by rrs_store, rrs_ctrl and relay_retransmission_scheduler.
package rrs_pkg;

  localparam int NUM_RELAYS_DEF = 4;
  localparam int NUM_SLOTS_DEF  = 4;

  localparam int RELAY_W   = 3;   // relay id, 0 means none
  localparam int RETRY_W   = 4;
  localparam int WINDOW_W  = 4;   // slots at this index and above are never awake
  localparam int RATIO_W   = 16;  // Q0.16 delivery ratio
  localparam int SLOT_AW   = 4;   // slot address bus, fits up to 16 slots
  localparam int SCAN_W    = RETRY_W + 1;
  localparam int UPD_W     = 4;
  localparam int MAXRT_RST = 3;
  localparam logic [UPD_W-1:0] UPDATES_NEEDED = UPD_W'(8);

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 32;

  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_NEW_FRAME = 2'd0;
  localparam cmd_t CMD_WINDOW    = 2'd1;
  localparam cmd_t CMD_RATIO     = 2'd2;
  localparam cmd_t CMD_OUTCOME   = 2'd3;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_ASK    = 2'd0;
  localparam kind_t KIND_SEND   = 2'd1;
  localparam kind_t KIND_ACK    = 2'd2;
  localparam kind_t KIND_REPORT = 2'd3;

  // write request into the relay / slot store
  typedef struct packed {
    logic                win_we;
    logic                ratio_we;
    logic [RELAY_W-1:0]  rel_idx;
    logic [WINDOW_W-1:0] win;
    logic [RATIO_W-1:0]  ratio;
    logic                tbl_we;
    logic [SLOT_AW-1:0]  slot_idx;
    logic [RELAY_W-1:0]  tbl_relay;
  } rrs_wr_t;

  // read data from the store
  typedef struct packed {
    logic [RATIO_W-1:0]  ratio;
    logic [WINDOW_W-1:0] window;
    logic [RELAY_W-1:0]  relay;
  } rrs_rd_t;

  // one result item
  typedef struct packed {
    kind_t               kind;
    logic [RELAY_W-1:0]  target;
    logic [RETRY_W-1:0]  retry;
    logic [RELAY_W-1:0]  rrel;
    logic [RATIO_W-1:0]  ratio;
    logic                last;
  } rrs_res_t;

endpackage

// ===== src/rrs_store.sv =====
// Relay windows, ratios, seen flags and the slot-to-relay table.
// One read address per array per cycle. Depends on rrs_pkg.
module rrs_store #(
  parameter int NUM_RELAYS = rrs_pkg::NUM_RELAYS_DEF,
  parameter int NUM_SLOTS  = rrs_pkg::NUM_SLOTS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rrs_pkg::rrs_wr_t                  wr_i,
  input  logic [rrs_pkg::RELAY_W-1:0]       rel_addr_i,
  input  logic [rrs_pkg::SLOT_AW-1:0]       slot_addr_i,
  output rrs_pkg::rrs_rd_t                  rd_o,
  output logic [NUM_RELAYS-1:0]             seen_o
);

  localparam int REL_IW  = (NUM_RELAYS > 1) ? $clog2(NUM_RELAYS) : 1;
  localparam int SLOT_IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  logic [rrs_pkg::WINDOW_W-1:0] win_q   [NUM_RELAYS];
  logic [rrs_pkg::RATIO_W-1:0]  ratio_q [NUM_RELAYS];
  logic [rrs_pkg::RELAY_W-1:0]  tbl_q   [NUM_SLOTS];
  logic [NUM_RELAYS-1:0]        seen_q;

  logic [REL_IW-1:0]  wr_rel;
  logic [SLOT_IW-1:0] wr_slot;
  logic [REL_IW-1:0]  rd_rel;
  logic [SLOT_IW-1:0] rd_slot;

  assign wr_rel  = wr_i.rel_idx[REL_IW-1:0];
  assign wr_slot = wr_i.slot_idx[SLOT_IW-1:0];
  assign rd_rel  = rel_addr_i[REL_IW-1:0];
  assign rd_slot = slot_addr_i[SLOT_IW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_RELAYS; k++) begin
        win_q[k]   <= '0;
        ratio_q[k] <= '0;
      end
      for (int s = 0; s < NUM_SLOTS; s++) begin
        tbl_q[s] <= '0;
      end
      seen_q <= '0;
    end else begin
      if (wr_i.win_we) begin
        win_q[wr_rel]  <= wr_i.win;
        seen_q[wr_rel] <= 1'b1;
      end
      if (wr_i.ratio_we) begin
        ratio_q[wr_rel] <= wr_i.ratio;
      end
      if (wr_i.tbl_we) begin
        tbl_q[wr_slot] <= wr_i.tbl_relay;
      end
    end
  end

  assign rd_o.ratio  = ratio_q[rd_rel];
  assign rd_o.window = win_q[rd_rel];
  assign rd_o.relay  = tbl_q[rd_slot];
  assign seen_o      = seen_q;

endmodule

// ===== src/rrs_ctrl.sv =====
// Sequencer: command decode, table rebuild over relays x slots with one
// ratio comparator, slot selection scan and the result register. Depends on rrs_pkg.
module rrs_ctrl #(
  parameter int NUM_RELAYS = rrs_pkg::NUM_RELAYS_DEF,
  parameter int NUM_SLOTS  = rrs_pkg::NUM_SLOTS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rrs_pkg::RETRY_W-1:0]       cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  rrs_pkg::cmd_t                     cmd_i,
  input  logic [rrs_pkg::RELAY_W-1:0]       relay_id_i,
  input  logic [rrs_pkg::RETRY_W-1:0]       retry_i,
  input  logic [rrs_pkg::WINDOW_W-1:0]      window_i,
  input  logic [rrs_pkg::RATIO_W-1:0]       ratio_i,
  input  logic                              failed_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output rrs_pkg::rrs_res_t                 res_o,
  output rrs_pkg::rrs_wr_t                  wr_o,
  output logic [rrs_pkg::RELAY_W-1:0]       rel_addr_o,
  output logic [rrs_pkg::SLOT_AW-1:0]       slot_addr_o,
  input  rrs_pkg::rrs_rd_t                  rd_i,
  input  logic [NUM_RELAYS-1:0]             seen_i
);

  localparam int REL_IW   = (NUM_RELAYS > 1) ? $clog2(NUM_RELAYS) : 1;
  localparam int SLOT_IW  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int LAST_REL = (NUM_RELAYS < 7) ? NUM_RELAYS : 7;

  localparam logic [2:0] S_IDLE        = 3'd0;
  localparam logic [2:0] S_RB_REL      = 3'd1;
  localparam logic [2:0] S_RB_SLOT     = 3'd2;
  localparam logic [2:0] S_SEL         = 3'd3;
  localparam logic [2:0] S_WAIT_REPORT = 3'd4;
  localparam logic [2:0] S_WAIT_LAST   = 3'd5;

  logic [2:0]                    state_q, state_d;
  logic [rrs_pkg::RETRY_W-1:0]   max_q, max_d;
  logic [rrs_pkg::UPD_W-1:0]     upd_q, upd_d;
  logic [rrs_pkg::RETRY_W-1:0]   retry_q, retry_d;
  logic                          acked_q, acked_d;
  logic                          waiting_q, waiting_d;
  logic [rrs_pkg::RELAY_W-1:0]   resp_q, resp_d;
  logic                          res_valid_q, res_valid_d;

  logic [rrs_pkg::RELAY_W-1:0]   rel_q, rel_d;
  logic [SLOT_IW-1:0]            i_q, i_d;
  logic [1:0]                    n_q, n_d;
  logic [NUM_SLOTS-1:0]          cand_q, cand_d;
  logic [rrs_pkg::RATIO_W-1:0]   mine_q, mine_d;
  logic [rrs_pkg::WINDOW_W-1:0]  win_q, win_d;
  logic [rrs_pkg::SCAN_W-1:0]    r_q, r_d;
  rrs_pkg::rrs_res_t             res_q, res_d;

  logic                          accept;
  logic                          out_fire;
  logic [rrs_pkg::UPD_W-1:0]     upd_inc;
  logic [rrs_pkg::RELAY_W-1:0]   rel_m1;
  logic [REL_IW-1:0]             seen_idx;
  logic [rrs_pkg::RELAY_W-1:0]   held;
  logic [rrs_pkg::RATIO_W-1:0]   held_ratio;
  logic [rrs_pkg::SLOT_AW-1:0]   i_ext;
  logic                          awake;
  logic                          take;
  logic                          rel_done;
  logic                          in_range;
  logic                          sel_ok;
  logic [rrs_pkg::SCAN_W-1:0]    r_p1;
  logic [rrs_pkg::RETRY_W-1:0]   r_sat;
  logic [rrs_pkg::RETRY_W-1:0]   r_p1_sat;

  function automatic logic rel_ok(logic [rrs_pkg::RELAY_W-1:0] id);
    return (id != '0) && (32'(id) <= NUM_RELAYS);
  endfunction

  function automatic rrs_pkg::rrs_res_t mk_res(rrs_pkg::kind_t k,
                                               logic [rrs_pkg::RELAY_W-1:0] tgt,
                                               logic [rrs_pkg::RETRY_W-1:0] rt,
                                               logic [rrs_pkg::RELAY_W-1:0] rr,
                                               logic [rrs_pkg::RATIO_W-1:0] rat,
                                               logic lst);
    rrs_pkg::rrs_res_t r;
    r.kind   = k;
    r.target = tgt;
    r.retry  = rt;
    r.rrel   = rr;
    r.ratio  = rat;
    r.last   = lst;
    return r;
  endfunction

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i & in_ready_o;
  assign out_valid_o = res_valid_q;
  assign out_fire    = res_valid_q & out_ready_i;
  assign res_o       = res_q;

  assign upd_inc  = (upd_q == {rrs_pkg::UPD_W{1'b1}}) ? upd_q : upd_q + 1'b1;
  assign rel_m1   = rel_q - 1'b1;
  assign seen_idx = rel_m1[REL_IW-1:0];
  assign rel_done = (rel_q == rrs_pkg::RELAY_W'(LAST_REL));

  // rebuild step: compare holder's ratio against this relay's
  assign held       = rd_i.relay;
  assign held_ratio = rel_ok(held) ? rd_i.ratio : '0;
  assign i_ext      = rrs_pkg::SLOT_AW'(i_q);
  assign awake      = (i_ext < rrs_pkg::SLOT_AW'(rrs_pkg::WINDOW_W)) && win_q[i_ext[1:0]];
  assign take       = awake && (((held_ratio < mine_q) && (n_q == '0)) ||
                                (cand_q[i_q] && (n_q == '0)) || (held == '0));

  // selection step
  assign in_range = (32'(r_q) < NUM_SLOTS);
  assign sel_ok   = in_range && (r_q <= {1'b0, max_q});
  assign r_p1     = r_q + 1'b1;
  assign r_sat    = r_q[rrs_pkg::RETRY_W] ? {rrs_pkg::RETRY_W{1'b1}} : r_q[rrs_pkg::RETRY_W-1:0];
  assign r_p1_sat = r_p1[rrs_pkg::RETRY_W] ? {rrs_pkg::RETRY_W{1'b1}}
                                           : r_p1[rrs_pkg::RETRY_W-1:0];

  always_comb begin
    state_d     = state_q;
    max_d       = max_q;
    upd_d       = upd_q;
    retry_d     = retry_q;
    acked_d     = acked_q;
    waiting_d   = waiting_q;
    resp_d      = resp_q;
    res_valid_d = res_valid_q;
    rel_d       = rel_q;
    i_d         = i_q;
    n_d         = n_q;
    cand_d      = cand_q;
    mine_d      = mine_q;
    win_d       = win_q;
    r_d         = r_q;
    res_d       = res_q;
    wr_o        = '0;
    rel_addr_o  = resp_q - 1'b1;
    slot_addr_o = i_ext;

    if (cfg_we_i) begin
      max_d = cfg_wdata_i;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd_i)
            rrs_pkg::CMD_NEW_FRAME: begin
              retry_d     = retry_i;
              acked_d     = 1'b0;
              waiting_d   = 1'b1;
              upd_d       = '0;
              res_d       = mk_res(rrs_pkg::KIND_ASK, '0, '0, '0, '0, 1'b1);
              res_valid_d = 1'b1;
              state_d     = S_WAIT_LAST;
            end
            rrs_pkg::CMD_WINDOW, rrs_pkg::CMD_RATIO: begin
              wr_o.win_we   = (cmd_i == rrs_pkg::CMD_WINDOW) && rel_ok(relay_id_i);
              wr_o.ratio_we = (cmd_i == rrs_pkg::CMD_RATIO) && rel_ok(relay_id_i);
              wr_o.rel_idx  = relay_id_i - 1'b1;
              wr_o.win      = window_i;
              wr_o.ratio    = ratio_i;
              upd_d         = upd_inc;
              if (upd_inc == rrs_pkg::UPDATES_NEEDED) begin
                waiting_d = 1'b0;
                rel_d     = rrs_pkg::RELAY_W'(1);
                cand_d    = '1;
                state_d   = S_RB_REL;
              end
            end
            rrs_pkg::CMD_OUTCOME: begin
              resp_d  = relay_id_i;
              retry_d = retry_i;
              acked_d = ~failed_i;
              if (waiting_q) begin
                if (upd_q == '0) begin
                  res_d       = mk_res(rrs_pkg::KIND_ASK, '0, '0, '0, '0, 1'b1);
                  res_valid_d = 1'b1;
                  state_d     = S_WAIT_LAST;
                end
              end else begin
                r_d     = {1'b0, retry_i};
                state_d = S_SEL;
              end
            end
            default: ;
          endcase
        end
      end

      S_RB_REL: begin
        rel_addr_o = rel_m1;
        if (seen_i[seen_idx]) begin
          mine_d  = rd_i.ratio;
          win_d   = rd_i.window;
          i_d     = '0;
          n_d     = '0;
          state_d = S_RB_SLOT;
        end else if (rel_done) begin
          r_d     = {1'b0, retry_q};
          state_d = S_SEL;
        end else begin
          rel_d = rel_q + 1'b1;
        end
      end

      S_RB_SLOT: begin
        slot_addr_o = i_ext;
        rel_addr_o  = held - 1'b1;
        if (take) begin
          wr_o.tbl_we    = 1'b1;
          wr_o.slot_idx  = i_ext;
          wr_o.tbl_relay = rel_q;
          n_d            = (n_q == 2'd2) ? n_q : n_q + 2'd1;
          cand_d[i_q]    = (n_q != '0);
        end
        if (i_q == SLOT_IW'(NUM_SLOTS - 1)) begin
          if (rel_done) begin
            r_d     = {1'b0, retry_q};
            state_d = S_SEL;
          end else begin
            rel_d   = rel_q + 1'b1;
            state_d = S_RB_REL;
          end
        end else begin
          i_d = i_q + 1'b1;
        end
      end

      S_SEL: begin
        slot_addr_o = rrs_pkg::SLOT_AW'(r_q[SLOT_IW-1:0]);
        if (in_range && (rd_i.relay == '0)) begin
          r_d = r_p1;
        end else if (sel_ok && !acked_q) begin
          retry_d     = r_p1_sat;
          res_d       = mk_res(rrs_pkg::KIND_SEND, rd_i.relay, r_p1_sat, '0, '0, 1'b1);
          res_valid_d = 1'b1;
          state_d     = S_WAIT_LAST;
        end else if (sel_ok) begin
          retry_d     = r_q[rrs_pkg::RETRY_W-1:0];
          res_d       = mk_res(rrs_pkg::KIND_ACK, '0, '0, '0, '0, 1'b1);
          res_valid_d = 1'b1;
          state_d     = S_WAIT_LAST;
        end else begin
          // out of slots or over the limit: ack, then give-up report
          retry_d     = r_sat;
          res_d       = mk_res(rrs_pkg::KIND_ACK, '0, '0, '0, '0, 1'b0);
          res_valid_d = 1'b1;
          state_d     = S_WAIT_REPORT;
        end
      end

      S_WAIT_REPORT: begin
        rel_addr_o = resp_q - 1'b1;
        if (out_fire) begin
          res_d   = mk_res(rrs_pkg::KIND_REPORT, '0, retry_q, resp_q,
                           rel_ok(resp_q) ? rd_i.ratio : '0, 1'b1);
          state_d = S_WAIT_LAST;
        end
      end

      S_WAIT_LAST: begin
        if (out_fire) begin
          res_valid_d = 1'b0;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      max_q       <= rrs_pkg::RETRY_W'(rrs_pkg::MAXRT_RST);
      upd_q       <= '0;
      retry_q     <= '0;
      acked_q     <= 1'b0;
      waiting_q   <= 1'b0;
      resp_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      max_q       <= max_d;
      upd_q       <= upd_d;
      retry_q     <= retry_d;
      acked_q     <= acked_d;
      waiting_q   <= waiting_d;
      resp_q      <= resp_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rel_q  <= rel_d;
    i_q    <= i_d;
    n_q    <= n_d;
    cand_q <= cand_d;
    mine_q <= mine_d;
    win_q  <= win_d;
    r_q    <= r_d;
    res_q  <= res_d;
  end

endmodule

// ===== src/relay_retransmission_scheduler.sv =====
// Relay retransmission scheduler, top level: stream ports and field packing.
// Instantiates rrs_ctrl and rrs_store; depends on rrs_pkg.

// One request is taken at a time; s_axis_tready is high only while the block is
// idle. A new-frame request, an update that is not the eighth, or an outcome while
// waiting for updates is handled straight from idle; a result that it gives waits
// on m_axis_tready. The eighth update rebuilds the slot table: the sequencer walks
// each relay up to min(NUM_RELAYS,7) and each slot of every relay with a stored
// window through a single ratio comparator; selection then scans one slot a cycle.
// An outcome outside the update phase goes straight to the selection scan. Give-up
// produces two results in turn, the acknowledge (tlast low) then the report.
// Config writes land at once.
module relay_retransmission_scheduler #(
  parameter int NUM_RELAYS = rrs_pkg::NUM_RELAYS_DEF,
  parameter int NUM_SLOTS  = rrs_pkg::NUM_SLOTS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rrs_pkg::RETRY_W-1:0]       cfg_wdata_i,    // max_retransmissions
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // relay_id[2:0], retry_count_in[6:3], window_bits[10:7],
  // delivery_ratio[26:11], failed[27], zero[31:28]
  input  logic [rrs_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  input  logic [1:0]                        s_axis_tuser,   // cmd[1:0]
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // target_relay[2:0], retry_count_out[6:3], report_relay[9:7],
  // report_ratio[25:10], zero[31:26]
  output logic [rrs_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  output logic [1:0]                        m_axis_tuser,   // kind[1:0]
  output logic                              m_axis_tlast
);

  rrs_pkg::rrs_wr_t               wr;
  rrs_pkg::rrs_rd_t               rd;
  rrs_pkg::rrs_res_t              res;
  logic [rrs_pkg::RELAY_W-1:0]    rel_addr;
  logic [rrs_pkg::SLOT_AW-1:0]    slot_addr;
  logic [NUM_RELAYS-1:0]          seen;

  rrs_ctrl #(
    .NUM_RELAYS (NUM_RELAYS),
    .NUM_SLOTS  (NUM_SLOTS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .cmd_i       (s_axis_tuser),
    .relay_id_i  (s_axis_tdata[2:0]),
    .retry_i     (s_axis_tdata[6:3]),
    .window_i    (s_axis_tdata[10:7]),
    .ratio_i     (s_axis_tdata[26:11]),
    .failed_i    (s_axis_tdata[27]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .res_o       (res),
    .wr_o        (wr),
    .rel_addr_o  (rel_addr),
    .slot_addr_o (slot_addr),
    .rd_i        (rd),
    .seen_i      (seen)
  );

  rrs_store #(
    .NUM_RELAYS (NUM_RELAYS),
    .NUM_SLOTS  (NUM_SLOTS)
  ) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (wr),
    .rel_addr_i  (rel_addr),
    .slot_addr_i (slot_addr),
    .rd_o        (rd),
    .seen_o      (seen)
  );

  assign m_axis_tdata = {6'd0, res.ratio, res.rrel, res.retry, res.target};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule
